[design/cda_pkg.sv]
// shared types, constants and calendar helpers for the calendar date adder
package cda_pkg;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_DAYS   = 2'd1;
    localparam logic [1:0] MODE_MONTHS = 2'd2;
    localparam logic [1:0] MODE_YEARS  = 2'd3;

    localparam logic [3:0] MONTH_JAN = 4'd0;
    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_APR = 4'd3;
    localparam logic [3:0] MONTH_JUN = 4'd5;
    localparam logic [3:0] MONTH_SEP = 4'd8;
    localparam logic [3:0] MONTH_NOV = 4'd10;
    localparam logic [3:0] MONTH_DEC = 4'd11;

    localparam logic [4:0] DAYS_SHORT = 5'd28;
    localparam logic [4:0] DAYS_LEAP  = 5'd29;
    localparam logic [4:0] DAYS_MID   = 5'd30;
    localparam logic [4:0] DAYS_LONG  = 5'd31;
    localparam logic [4:0] LAST_DAY_DEC = 5'd30;

    // remainder of the shared divider fits below the largest divisor
    localparam int unsigned REM_BITS = 11;
    localparam logic [REM_BITS:0] FOUR_YEAR_DAYS  = 12'd1461;
    localparam logic [REM_BITS:0] MONTHS_PER_YEAR = 12'd12;

    localparam logic [10:0] RESET_YEAR  = 11'd1985;
    localparam logic [3:0]  RESET_MONTH = MONTH_NOV;
    localparam logic [4:0]  RESET_DAY   = 5'd4;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] amount;
        logic [15:0]        load_year;
        logic [3:0]         load_month;
        logic [4:0]         load_day;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic        year_saturated;
    } t_out_item;

    typedef struct packed {
        logic cap;
        logic load;
        logic years;
        logic div_init;
        logic div_step;
        logic mon_apply;
        logic day_apply;
        logic walk_step;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       div_last;
        logic       rem_zero;
    } t_dp_status;

    function automatic logic [4:0] month_len(input logic [1:0] year_lo, input logic [3:0] month);
        logic [4:0] len;
        case (month) inside
            MONTH_FEB: len = (year_lo != 2'd0) ? DAYS_SHORT : DAYS_LEAP;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_MID;
            default: len = DAYS_LONG;
        endcase
        return len;
    endfunction

    function automatic logic [4:0] clamp_day(input logic [4:0] day, input logic [4:0] len);
        return (day > len - 5'd1) ? len - 5'd1 : day;
    endfunction

endpackage

[design/cda_datapath.sv]
// date registers, reciprocal divider and month walker
module cda_datapath #(
    parameter int YEAR_BITS   = 16,
    parameter int AMOUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cda_pkg::t_dp_cmd      i_cmd,
    input  cda_pkg::t_in_item     i_item,
    output cda_pkg::t_dp_status   o_status,
    output cda_pkg::t_out_item    o_result
);

    localparam int UW  = AMOUNT_BITS + 1;
    localparam int YRW = (YEAR_BITS > 11) ? YEAR_BITS : 11;
    localparam int WW  = ((YRW > UW) ? YRW : UW) + 3;
    localparam int RW  = cda_pkg::REM_BITS;
    localparam int DW  = UW + RW + 1;
    localparam logic [WW-1:0] YEAR_MAX_W = WW'((64'd1 << YEAR_BITS) - 64'd1);

    // reciprocals scaled by 2^UW and rounded down, so the estimate is low by at most one
    localparam logic [UW-1:0] RECIP_DAYS =
        UW'((65'd1 << UW) / 65'(cda_pkg::FOUR_YEAR_DAYS));
    localparam logic [UW-1:0] RECIP_MONTHS =
        UW'((65'd1 << UW) / 65'(cda_pkg::MONTHS_PER_YEAR));

    localparam logic [1:0] DIV_EST = 2'd0;
    localparam logic [1:0] DIV_SUB = 2'd1;
    localparam logic [1:0] DIV_FIX = 2'd2;

    logic [YRW-1:0]         r_year, n_year;
    logic [3:0]             r_month, n_month;
    logic [4:0]             r_day, n_day;
    logic                   r_sat, n_sat;
    logic [1:0]             r_mode;
    logic [AMOUNT_BITS-1:0] r_amt;
    logic [YRW-1:0]         r_ly;
    logic [3:0]             r_lm;
    logic [4:0]             r_ld;
    logic                   r_neg, n_neg;
    logic [UW-1:0]          r_dnum, n_dnum;
    logic [UW-1:0]          r_dq, n_dq;
    logic [RW:0]            r_ddif, n_ddif;
    logic [RW-1:0]          r_drem, n_drem;
    logic [1:0]             r_dcnt, n_dcnt;
    logic [RW-1:0]          r_rem, n_rem;

    logic [AMOUNT_BITS+15:0] amt_ext;
    logic [YRW+15:0]         ly_ext;
    logic [WW-1:0]           year_w, amt_w, q_w, qf_w, y_sum, ym_w;
    logic [WW+15:0]          yo_ext;
    logic [UW-1:0]           s_div, u_div, recip;
    logic [2*UW-1:0]         prod;
    logic [DW-1:0]           qd_w, dif_w;
    logic [RW:0]             divisor;
    logic                    dif_ge;
    logic                    rem_nz;
    logic [3:0]              m_new, m_prev, lm_sat;
    logic [YRW-1:0]          y_prev;
    logic [4:0]              len_cur, len_prev, rest, ld_day;

    always_comb begin
        amt_ext = {{AMOUNT_BITS{1'b0}}, i_item.amount};
        ly_ext  = {{YRW{1'b0}}, i_item.load_year};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year  <= YRW'(cda_pkg::RESET_YEAR);
            r_month <= cda_pkg::RESET_MONTH;
            r_day   <= cda_pkg::RESET_DAY;
            r_sat   <= 1'b0;
        end else begin
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            r_sat   <= n_sat;
        end
        if (i_cmd.cap) begin
            r_mode <= i_item.mode;
            r_amt  <= amt_ext[AMOUNT_BITS-1:0];
            // load year is cut to the year range, then widened for storage
            r_ly   <= YRW'((ly_ext & {{16{1'b0}}, YRW'(YEAR_MAX_W)}) & {(YRW+16){1'b1}});
            r_lm   <= i_item.load_month;
            r_ld   <= i_item.load_day;
        end
        r_neg  <= n_neg;
        r_dnum <= n_dnum;
        r_dq   <= n_dq;
        r_ddif <= n_ddif;
        r_drem <= n_drem;
        r_dcnt <= n_dcnt;
        r_rem  <= n_rem;
    end

    always_comb begin
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_sat   = r_sat;
        n_neg   = r_neg;
        n_dnum  = r_dnum;
        n_dq    = r_dq;
        n_ddif  = r_ddif;
        n_drem  = r_drem;
        n_dcnt  = r_dcnt;
        n_rem   = r_rem;

        year_w = {{(WW-YRW){1'b0}}, r_year};
        amt_w  = {{(WW-AMOUNT_BITS){r_amt[AMOUNT_BITS-1]}}, r_amt};
        q_w    = {{(WW-UW){1'b0}}, r_dq};
        rem_nz = (r_drem != '0);

        s_div = {r_amt[AMOUNT_BITS-1], r_amt};
        if (r_mode == cda_pkg::MODE_MONTHS) begin
            s_div = s_div + {{(UW-4){1'b0}}, r_month};
        end
        u_div = s_div[UW-1] ? (~s_div + UW'(1)) : s_div;

        divisor = (r_mode == cda_pkg::MODE_DAYS) ? cda_pkg::FOUR_YEAR_DAYS
                                                 : cda_pkg::MONTHS_PER_YEAR;
        recip   = (r_mode == cda_pkg::MODE_DAYS) ? RECIP_DAYS : RECIP_MONTHS;
        prod    = {{UW{1'b0}}, r_dnum} * {{UW{1'b0}}, recip};
        qd_w    = {{(RW+1){1'b0}}, r_dq} * {{UW{1'b0}}, divisor};
        dif_w   = {{(RW+1){1'b0}}, r_dnum} - qd_w;
        dif_ge  = (r_ddif >= divisor);

        len_cur  = cda_pkg::month_len(r_year[1:0], r_month);
        rest     = len_cur - r_day;
        m_prev   = (r_month == cda_pkg::MONTH_JAN) ? cda_pkg::MONTH_DEC : r_month - 4'd1;
        y_prev   = (r_month == cda_pkg::MONTH_JAN) ? r_year - YRW'(1) : r_year;
        len_prev = cda_pkg::month_len(y_prev[1:0], m_prev);

        lm_sat = (r_lm > cda_pkg::MONTH_DEC) ? cda_pkg::MONTH_DEC : r_lm;
        ld_day = (r_ld == 5'd0) ? 5'd0 : r_ld - 5'd1;

        qf_w  = q_w;
        m_new = r_drem[3:0];
        y_sum = year_w;

        if (i_cmd.cap) begin
            n_sat = 1'b0;
        end

        if (i_cmd.load) begin
            n_year  = r_ly;
            n_month = lm_sat;
            n_day   = cda_pkg::clamp_day(ld_day, cda_pkg::month_len(r_ly[1:0], lm_sat));
        end

        if (i_cmd.years) begin
            y_sum = year_w + amt_w;
            if (y_sum[WW-1]) begin
                n_year = '0;
                n_sat  = 1'b1;
            end else if (y_sum > YEAR_MAX_W) begin
                n_year = YRW'(YEAR_MAX_W);
                n_sat  = 1'b1;
            end else begin
                n_year = y_sum[YRW-1:0];
            end
            n_day = cda_pkg::clamp_day(r_day, cda_pkg::month_len(n_year[1:0], r_month));
        end

        if (i_cmd.div_init) begin
            n_neg  = s_div[UW-1];
            n_dnum = u_div;
            n_dcnt = DIV_EST;
        end

        if (i_cmd.div_step) begin
            n_dcnt = r_dcnt + 2'd1;
            case (r_dcnt)
                DIV_EST: begin
                    n_dq = prod[2*UW-1:UW];
                end
                DIV_SUB: begin
                    n_ddif = dif_w[RW:0];
                end
                default: begin
                    // one correction brings the estimate up to the true quotient
                    if (dif_ge) begin
                        n_dq   = r_dq + UW'(1);
                        n_drem = RW'(r_ddif - divisor);
                    end else begin
                        n_drem = r_ddif[RW-1:0];
                    end
                end
            endcase
        end

        if (i_cmd.mon_apply) begin
            // floor division for a negative month count
            if (r_neg) begin
                qf_w  = q_w + WW'(rem_nz);
                m_new = rem_nz ? 4'(cda_pkg::MONTHS_PER_YEAR) - r_drem[3:0] : 4'd0;
                y_sum = year_w - qf_w;
            end else begin
                y_sum = year_w + qf_w;
            end
            if (y_sum[WW-1]) begin
                n_year  = '0;
                n_month = cda_pkg::MONTH_JAN;
                n_sat   = 1'b1;
            end else if (y_sum > YEAR_MAX_W) begin
                n_year  = YRW'(YEAR_MAX_W);
                n_month = cda_pkg::MONTH_DEC;
                n_sat   = 1'b1;
            end else begin
                n_year  = y_sum[YRW-1:0];
                n_month = m_new;
            end
            n_day = cda_pkg::clamp_day(r_day, cda_pkg::month_len(n_year[1:0], n_month));
        end

        if (i_cmd.day_apply) begin
            y_sum = r_neg ? (year_w - (q_w << 2)) : (year_w + (q_w << 2));
            n_rem = r_drem;
            if (r_neg && y_sum[WW-1]) begin
                n_year  = '0;
                n_month = cda_pkg::MONTH_JAN;
                n_day   = 5'd0;
                n_sat   = 1'b1;
                n_rem   = '0;
            end else if (!r_neg && (y_sum > YEAR_MAX_W)) begin
                n_year  = YRW'(YEAR_MAX_W);
                n_month = cda_pkg::MONTH_DEC;
                n_day   = cda_pkg::LAST_DAY_DEC;
                n_sat   = 1'b1;
                n_rem   = '0;
            end else begin
                n_year = y_sum[YRW-1:0];
            end
        end

        if (i_cmd.walk_step) begin
            if (!r_neg) begin
                if (r_rem >= {{(RW-5){1'b0}}, rest}) begin
                    if ((r_month == cda_pkg::MONTH_DEC) && (year_w == YEAR_MAX_W)) begin
                        n_day = cda_pkg::LAST_DAY_DEC;
                        n_sat = 1'b1;
                        n_rem = '0;
                    end else begin
                        n_rem = r_rem - {{(RW-5){1'b0}}, rest};
                        n_day = 5'd0;
                        if (r_month == cda_pkg::MONTH_DEC) begin
                            n_month = cda_pkg::MONTH_JAN;
                            n_year  = r_year + YRW'(1);
                        end else begin
                            n_month = r_month + 4'd1;
                        end
                    end
                end else begin
                    n_day = r_day + r_rem[4:0];
                    n_rem = '0;
                end
            end else begin
                if (r_rem > {{(RW-5){1'b0}}, r_day}) begin
                    if ((r_month == cda_pkg::MONTH_JAN) && (r_year == '0)) begin
                        n_day = 5'd0;
                        n_sat = 1'b1;
                        n_rem = '0;
                    end else begin
                        n_rem   = r_rem - {{(RW-5){1'b0}}, r_day} - RW'(1);
                        n_month = m_prev;
                        n_year  = y_prev;
                        n_day   = len_prev - 5'd1;
                    end
                end else begin
                    n_day = r_day - r_rem[4:0];
                    n_rem = '0;
                end
            end
        end
    end

    always_comb begin
        ym_w   = year_w & YEAR_MAX_W;
        yo_ext = {{16{1'b0}}, ym_w};
        o_result.cur_year       = yo_ext[15:0];
        o_result.cur_month      = r_month;
        o_result.cur_day        = r_day + 5'd1;
        o_result.year_saturated = r_sat;

        o_status.mode     = r_mode;
        o_status.div_last = (r_dcnt == DIV_FIX);
        o_status.rem_zero = (r_rem == '0);
    end

endmodule

[design/cda_control.sv]
// sequencer that steps the datapath through load, divide, apply and month walk
module cda_control (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  cda_pkg::t_dp_status   i_status,
    output cda_pkg::t_dp_cmd      o_cmd,
    output logic                  o_busy,
    output logic                  o_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIV,
        S_APPLY,
        S_WALK
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_status.mode)
                    cda_pkg::MODE_LOAD: begin
                        o_cmd.load = 1'b1;
                        n_state    = S_IDLE;
                        n_done     = 1'b1;
                    end
                    cda_pkg::MODE_YEARS: begin
                        o_cmd.years = 1'b1;
                        n_state     = S_IDLE;
                        n_done      = 1'b1;
                    end
                    default: begin
                        o_cmd.div_init = 1'b1;
                        n_state        = S_DIV;
                    end
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (i_status.mode == cda_pkg::MODE_MONTHS) begin
                    o_cmd.mon_apply = 1'b1;
                    n_state         = S_IDLE;
                    n_done          = 1'b1;
                end else begin
                    o_cmd.day_apply = 1'b1;
                    n_state         = S_WALK;
                end
            end
            S_WALK: begin
                if (i_status.rem_zero) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

[design/calendar_date_adder.sv]
// calendar date adder: holds one date and loads it or adds days, months or years
//
// An item is taken at a clock edge where i_start is high and o_busy is low.
// i_item.mode picks load, add days, add months or add years; i_item.amount is
// the signed count. Every item gives one result on o_result, valid for the
// single cycle in which o_done is high; nothing downstream can stall it.
// o_busy drops in that same cycle, so the next item may be started there.
// Division by 1461 or by 12 is a reciprocal multiply with one correction and
// runs as estimate, subtract and fix steps; the day walk crosses one month per
// step and ends with a final partial step.
// Reset (synchronous, active low) puts the held date at November 5, 1985,
// clears the saturation flag and returns the sequencer to idle.
// The year saturates at 0 and 2^YEAR_BITS-1 and raises year_saturated.
module calendar_date_adder #(
    parameter int YEAR_BITS   = 16,
    parameter int AMOUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  cda_pkg::t_in_item   i_item,
    output logic                o_busy,
    output logic                o_done,
    output cda_pkg::t_out_item  o_result
);

    cda_pkg::t_dp_cmd    cmd;
    cda_pkg::t_dp_status status;

    cda_control u_control (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_done   (o_done)
    );

    cda_datapath #(
        .YEAR_BITS   (YEAR_BITS),
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_status (status),
        .o_result (o_result)
    );

endmodule

[design/cda_checker.sv]
// port-level checks for the calendar date adder, bound to the top level
module cda_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_done,
    input cda_pkg::t_out_item o_result
);

    // a result strobe only comes once the item is finished
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_done))
        else $error("accepted item did not make the block busy");

    // one strobe per item, never two in a row
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_date_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_result.cur_month <= cda_pkg::MONTH_DEC) &&
                    (o_result.cur_day != 5'd0)))
        else $error("result date out of range");

endmodule

bind calendar_date_adder cda_checker u_cda_checker (.*);

[tb/sv/calendar_date_adder_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the calendar date adder: directed and random items
module calendar_date_adder_tb;

    localparam longint YEAR_TOP     = 65535;
    localparam longint DAYS_PER_4Y  = 1461;
    localparam longint MONTHS_IN_YR = 12;
    localparam int RANDOM_ITEMS = 540;
    localparam int LONG_GAP_MAX = 60;
    localparam int ITEM_CYCLES  = 1100;
    localparam int CYCLE_LIMIT  = (RANDOM_ITEMS + 25) * (ITEM_CYCLES + LONG_GAP_MAX) * 4;
    localparam int DRAIN_CYCLES = 200;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    cda_pkg::t_in_item  i_item  = '0;
    logic               o_busy;
    logic               o_done;
    cda_pkg::t_out_item o_result;

    cda_pkg::t_in_item  stim_items[$];
    cda_pkg::t_out_item want_dates[$];

    // held date of the predictor, day is zero-based
    longint held_year  = 1985;
    longint held_month = 10;
    longint held_day   = 4;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int idle_left      = 0;
    int calm_left      = 0;

    always #5 i_clk = ~i_clk;

    calendar_date_adder u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    function automatic longint month_days(input longint y, input longint m);
        if (m == cda_pkg::MONTH_FEB)
            return ((y & 3) != 0) ? cda_pkg::DAYS_SHORT : cda_pkg::DAYS_LEAP;
        if (m == cda_pkg::MONTH_APR || m == cda_pkg::MONTH_JUN ||
            m == cda_pkg::MONTH_SEP || m == cda_pkg::MONTH_NOV)
            return cda_pkg::DAYS_MID;
        return cda_pkg::DAYS_LONG;
    endfunction

    function automatic void trim_day();
        longint last;
        last = month_days(held_year, held_month) - 1;
        if (held_day > last)
            held_day = last;
    endfunction

    function automatic logic walk_days(input longint n);
        longint q;
        longint rest;
        if (n >= 0) begin
            // whole four-year blocks first, then month by month
            q = n / DAYS_PER_4Y;
            if (held_year + 4 * q > YEAR_TOP) begin
                held_year  = YEAR_TOP;
                held_month = cda_pkg::MONTH_DEC;
                held_day   = cda_pkg::LAST_DAY_DEC;
                return 1'b1;
            end
            held_year += 4 * q;
            n -= q * DAYS_PER_4Y;
            while (n > 0) begin
                rest = month_days(held_year, held_month) - held_day;
                if (n >= rest) begin
                    if (held_month == cda_pkg::MONTH_DEC && held_year == YEAR_TOP) begin
                        held_day = cda_pkg::LAST_DAY_DEC;
                        return 1'b1;
                    end
                    n -= rest;
                    held_day = 0;
                    if (held_month == cda_pkg::MONTH_DEC) begin
                        held_month = cda_pkg::MONTH_JAN;
                        held_year++;
                    end else begin
                        held_month++;
                    end
                end else begin
                    held_day += n;
                    n = 0;
                end
            end
        end else begin
            q = (-n) / DAYS_PER_4Y;
            if (held_year - 4 * q < 0) begin
                held_year  = 0;
                held_month = cda_pkg::MONTH_JAN;
                held_day   = 0;
                return 1'b1;
            end
            held_year -= 4 * q;
            n += q * DAYS_PER_4Y;
            while (n < 0) begin
                if (n < -held_day) begin
                    if (held_month == cda_pkg::MONTH_JAN && held_year == 0) begin
                        held_day = 0;
                        return 1'b1;
                    end
                    n += held_day + 1;
                    if (held_month == cda_pkg::MONTH_JAN) begin
                        held_month = cda_pkg::MONTH_DEC;
                        held_year--;
                    end else begin
                        held_month--;
                    end
                    held_day = month_days(held_year, held_month) - 1;
                end else begin
                    held_day += n;
                    n = 0;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic logic shift_months(input longint n);
        longint total;
        logic   sat;
        sat   = 1'b0;
        total = held_year * MONTHS_IN_YR + held_month + n;
        if (total < 0) begin
            total = 0;
            sat   = 1'b1;
        end
        if (total > YEAR_TOP * MONTHS_IN_YR + 11) begin
            total = YEAR_TOP * MONTHS_IN_YR + 11;
            sat   = 1'b1;
        end
        held_year  = total / MONTHS_IN_YR;
        held_month = total % MONTHS_IN_YR;
        trim_day();
        return sat;
    endfunction

    function automatic logic shift_years(input longint n);
        longint y;
        logic   sat;
        sat = 1'b0;
        y   = held_year + n;
        if (y < 0) begin
            y   = 0;
            sat = 1'b1;
        end
        if (y > YEAR_TOP) begin
            y   = YEAR_TOP;
            sat = 1'b1;
        end
        held_year = y;
        trim_day();
        return sat;
    endfunction

    function automatic cda_pkg::t_out_item next_date(input cda_pkg::t_in_item it);
        longint             n;
        logic               sat;
        cda_pkg::t_out_item r;
        n   = longint'($signed(it.amount));
        sat = 1'b0;
        case (it.mode)
            cda_pkg::MODE_LOAD: begin
                held_year  = it.load_year;
                held_month = (it.load_month > cda_pkg::MONTH_DEC) ? cda_pkg::MONTH_DEC
                                                                  : it.load_month;
                held_day   = (it.load_day == 0) ? 0 : it.load_day - 1;
                trim_day();
            end
            cda_pkg::MODE_DAYS:   sat = walk_days(n);
            cda_pkg::MODE_MONTHS: sat = shift_months(n);
            default:              sat = shift_years(n);
        endcase
        r.cur_year       = held_year[15:0];
        r.cur_month      = held_month[3:0];
        r.cur_day        = 5'(held_day + 1);
        r.year_saturated = sat;
        return r;
    endfunction

    function automatic cda_pkg::t_in_item make_item(input logic [1:0] mode,
                                                    input logic [15:0] amount,
                                                    input logic [15:0] y,
                                                    input logic [3:0] m,
                                                    input logic [4:0] d);
        cda_pkg::t_in_item it;
        it.mode       = mode;
        it.amount     = amount;
        it.load_year  = y;
        it.load_month = m;
        it.load_day   = d;
        return it;
    endfunction

    // mostly short gaps, a few long ones, with calm stretches of back-to-back items
    function automatic int draw_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            calm_left = $urandom_range(10, 40);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, LONG_GAP_MAX);
    endfunction

    task automatic report_field(input string field, input logic [15:0] want_v,
                                input logic [15:0] got_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
        mismatch_count++;
    endtask

    // driver: start may rise while the block is busy, the item waits for acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !o_busy) begin
            want_dates.push_back(next_date(i_item));
            idle_left = draw_gap();
            if (idle_left == 0 && stim_items.size() > 0) begin
                i_item <= stim_items.pop_front();
            end else begin
                i_start <= 1'b0;
            end
        end else if (!i_start) begin
            if (idle_left > 0) begin
                idle_left--;
            end else if (stim_items.size() > 0) begin
                i_item  <= stim_items.pop_front();
                i_start <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cda_pkg::t_out_item want;
        if (i_rst_n && o_done) begin
            if (want_dates.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d sat %0b",
                         $time, o_result.cur_year, o_result.cur_month, o_result.cur_day,
                         o_result.year_saturated);
                mismatch_count++;
            end else begin
                want = want_dates.pop_front();
                if (o_result.cur_year !== want.cur_year)
                    report_field("cur_year", want.cur_year, o_result.cur_year);
                if (o_result.cur_month !== want.cur_month)
                    report_field("cur_month", want.cur_month, o_result.cur_month);
                if (o_result.cur_day !== want.cur_day)
                    report_field("cur_day", want.cur_day, o_result.cur_day);
                if (o_result.year_saturated !== want.year_saturated)
                    report_field("year_saturated", want.year_saturated,
                                 o_result.year_saturated);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int          sel;
        int          pick;
        logic [1:0]  mode;
        logic [15:0] amt;
        logic [15:0] yr;

        // directed: reset date, leap rules, load repairs, saturation at both ends
        stim_items.push_back(make_item(cda_pkg::MODE_DAYS, 16'h0000, 16'hFFFF, 4'hF, 5'h1F));
        stim_items.push_back(make_item(cda_pkg::MODE_LOAD, 16'h0000, 16'd2024,
                                       cda_pkg::MONTH_FEB, 5'd29));
        stim_items.push_back(make_item(cda_pkg::MODE_YEARS, 16'h0001, 16'h0000, 4'h0, 5'h00));
        stim_items.push_back(make_item(cda_pkg::MODE_LOAD, 16'hFFFF, 16'd2100,
                                       cda_pkg::MONTH_FEB, 5'd29));
        stim_items.push_back(make_item(cda_pkg::MODE_LOAD, 16'h0000, 16'd2023,
                                       cda_pkg::MONTH_FEB, 5'd31));
        stim_items.push_back(make_item(cda_pkg::MODE_LOAD, 16'h0000, 16'd1999, 4'd15, 5'd0));
        stim_items.push_back(make_item(cda_pkg::MODE_LOAD, 16'h0000, 16'd2000,
                                       cda_pkg::MONTH_APR, 5'd31));
        stim_items.push_back(make_item(cda_pkg::MODE_LOAD, 16'h0000, 16'hFFFF,
                                       cda_pkg::MONTH_DEC, 5'd31));
        stim_items.push_back(make_item(cda_pkg::MODE_DAYS, 16'h0001, 16'h0000, 4'h0, 5'h00));
        stim_items.push_back(make_item(cda_pkg::MODE_DAYS, 16'h8000, 16'h0000, 4'h0, 5'h00));
        stim_items.push_back(make_item(cda_pkg::MODE_DAYS, 16'h7FFF, 16'h0000, 4'h0, 5'h00));
        stim_items.push_back(make_item(cda_pkg::MODE_LOAD, 16'hFFFF, 16'h0000,
                                       cda_pkg::MONTH_JAN, 5'd1));
        stim_items.push_back(make_item(cda_pkg::MODE_DAYS, 16'hFFFF, 16'h0000, 4'h0, 5'h00));
        stim_items.push_back(make_item(cda_pkg::MODE_DAYS, 16'h7FFF, 16'h0000, 4'h0, 5'h00));
        stim_items.push_back(make_item(cda_pkg::MODE_MONTHS, 16'h8000, 16'h0000, 4'h0, 5'h00));
        stim_items.push_back(make_item(cda_pkg::MODE_LOAD, 16'h0000, 16'h0000,
                                       cda_pkg::MONTH_JAN, 5'd31));
        stim_items.push_back(make_item(cda_pkg::MODE_MONTHS, 16'h0001, 16'h0000, 4'h0, 5'h00));
        stim_items.push_back(make_item(cda_pkg::MODE_MONTHS, 16'hFFFE, 16'h0000, 4'h0, 5'h00));
        stim_items.push_back(make_item(cda_pkg::MODE_LOAD, 16'h0000, 16'hFFFF,
                                       cda_pkg::MONTH_NOV, 5'd30));
        stim_items.push_back(make_item(cda_pkg::MODE_MONTHS, 16'h0001, 16'h0000, 4'h0, 5'h00));
        stim_items.push_back(make_item(cda_pkg::MODE_MONTHS, 16'h7FFF, 16'h0000, 4'h0, 5'h00));
        stim_items.push_back(make_item(cda_pkg::MODE_YEARS, 16'h8000, 16'h0000, 4'h0, 5'h00));
        stim_items.push_back(make_item(cda_pkg::MODE_YEARS, 16'h7FFF, 16'h0000, 4'h0, 5'h00));
        stim_items.push_back(make_item(cda_pkg::MODE_YEARS, 16'h7FFF, 16'h0000, 4'h0, 5'h00));
        stim_items.push_back(make_item(cda_pkg::MODE_LOAD, 16'h0000, 16'd100,
                                       cda_pkg::MONTH_JUN, 5'd15));
        stim_items.push_back(make_item(cda_pkg::MODE_YEARS, 16'h8000, 16'h0000, 4'h0, 5'h00));

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 22)
                mode = cda_pkg::MODE_LOAD;
            else if (sel < 52)
                mode = cda_pkg::MODE_DAYS;
            else if (sel < 76)
                mode = cda_pkg::MODE_MONTHS;
            else
                mode = cda_pkg::MODE_YEARS;

            // loads land near either end of the year range now and then
            pick = $urandom_range(0, 99);
            if (pick < 10)
                yr = 16'($urandom_range(0, 3));
            else if (pick < 20)
                yr = 16'(YEAR_TOP - $urandom_range(0, 3));
            else
                yr = 16'($urandom);

            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                amt = 16'($urandom_range(0, 120) - 60);
            end else if (pick < 60) begin
                amt = 16'($urandom_range(0, 6000) - 3000);
            end else if (pick < 85) begin
                amt = 16'($urandom);
            end else begin
                case ($urandom_range(0, 3))
                    0:       amt = 16'h8000;
                    1:       amt = 16'h7FFF;
                    2:       amt = 16'hFFFF;
                    default: amt = 16'h0000;
                endcase
            end

            stim_items.push_back(make_item(mode, amt, yr, 4'($urandom_range(0, 15)),
                                           5'($urandom_range(0, 31))));
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_items.size() != 0 || i_start || want_dates.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (want_dates.size() != 0) begin
            $display("%0t: %0d results missing, expected year %0d, actual none",
                     $time, want_dates.size(), want_dates[0].cur_year);
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[calendar_date_adder.f]
design/cda_pkg.sv
design/cda_datapath.sv
design/cda_control.sv
design/calendar_date_adder.sv
design/cda_checker.sv
tb/sv/calendar_date_adder_tb.sv
